// File: sv/variable_frame_checker_macros.svh
// Assertion macros used by the checker in vfc_checker.sv
`ifndef VARIABLE_FRAME_CHECKER_MACROS_SVH
`define VARIABLE_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication, held off during reset
`define VFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("variable_frame_checker: implication failed");

// Next-cycle implication, held off during reset
`define VFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("variable_frame_checker: next-cycle implication failed");

// Next-cycle implication, checked through reset as well
`define VFC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("variable_frame_checker: reset behaviour failed");

`endif

// File: sv/vfc_pkg.sv
`timescale 1ns / 1ps

package vfc_pkg;

    localparam int BYTE_W   = 8;
    localparam int ERR_W    = 2;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 4;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h68;
    localparam logic [BYTE_W-1:0] END_BYTE   = 8'h16;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_LEN1   = 3'd1,
        PH_LEN2   = 3'd2,
        PH_START2 = 3'd3,
        PH_BODY   = 3'd4,
        PH_CSUM   = 3'd5,
        PH_END    = 3'd6
    } phase_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE   = 2'd0,
        ERR_HEADER = 2'd1,
        ERR_CSUM   = 2'd2,
        ERR_END    = 2'd3
    } err_t;

    typedef struct packed {
        logic [BYTE_W-1:0] body_byte;
        logic              body_valid;
        logic              frame_end;
        logic              frame_good;
        err_t              fault_kind;
        logic [BYTE_W-1:0] frame_length;
    } vfc_result_t;

endpackage

// File: sv/vfc_parser.sv
`timescale 1ns / 1ps

module vfc_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [vfc_pkg::BYTE_W-1:0]  rx_byte,
    output vfc_pkg::vfc_result_t        result
);
    import vfc_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] left_reg, left_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              matched_reg, matched_next;
    logic [BYTE_W-1:0] left_dec;

    assign left_dec = left_reg - BYTE_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            length_reg  <= '0;
            left_reg    <= '0;
            sum_reg     <= '0;
            matched_reg <= 1'b0;
        end else if (step) begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            left_reg    <= left_next;
            sum_reg     <= sum_next;
            matched_reg <= matched_next;
        end
    end

    // next state
    always_comb begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        left_next    = left_reg;
        sum_next     = sum_reg;
        matched_next = matched_reg;
        unique case (phase_reg)
            PH_LEN1: begin
                length_next = rx_byte;
                left_next   = rx_byte;
                phase_next  = PH_LEN2;
            end
            PH_LEN2: begin
                phase_next = (rx_byte == length_reg) ? PH_START2 : PH_HUNT;
            end
            PH_START2: begin
                if (rx_byte == START_BYTE) begin
                    phase_next = (left_reg == '0) ? PH_CSUM : PH_BODY;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            PH_BODY: begin
                sum_next  = sum_reg + rx_byte;
                left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = PH_CSUM;
                end
            end
            PH_CSUM: begin
                matched_next = (rx_byte == sum_reg);
                phase_next   = PH_END;
            end
            PH_END: begin
                phase_next = PH_HUNT;
            end
            default: begin
                if (rx_byte == START_BYTE) begin
                    length_next  = '0;
                    left_next    = '0;
                    sum_next     = '0;
                    matched_next = 1'b0;
                    phase_next   = PH_LEN1;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    // outputs
    always_comb begin
        result              = '0;
        result.fault_kind   = ERR_NONE;
        result.frame_length = length_next;
        unique case (phase_reg)
            PH_LEN2: begin
                if (rx_byte != length_reg) begin
                    result.frame_end  = 1'b1;
                    result.fault_kind = ERR_HEADER;
                end
            end
            PH_START2: begin
                if (rx_byte != START_BYTE) begin
                    result.frame_end  = 1'b1;
                    result.fault_kind = ERR_HEADER;
                end
            end
            PH_BODY: begin
                result.body_byte  = rx_byte;
                result.body_valid = 1'b1;
            end
            PH_END: begin
                result.frame_end = 1'b1;
                if (!matched_reg) begin
                    result.fault_kind = ERR_CSUM;
                end else if (rx_byte != END_BYTE) begin
                    result.fault_kind = ERR_END;
                end else begin
                    result.frame_good = 1'b1;
                end
            end
            default: begin
                result.frame_end = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/variable_frame_checker.sv
`timescale 1ns / 1ps

// Channel  Dir  tdata                      tuser / tlast
// s_       in   [7:0] rx_byte              -
// m_       out  [7:0] body_byte,           tuser [0] body_valid, [1] frame_good,
//               [15:8] frame_length        [3:2] fault_kind; tlast frame_end
//
// One item per cycle sustained while m_tready is high; an item is taken into the input register,
// then the parser state and the result register are updated from it.
// Synchronous active-low reset returns the parser to the start-byte hunt, empties both registers.
// A stalled result holds the result register; the input register keeps taking an item
// while the result register drains in the same cycle.
module variable_frame_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vfc_pkg::IN_DATA_W-1:0] s_tdata,   // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vfc_pkg::OUT_DATA_W-1:0] m_tdata,  // [7:0] body_byte, [15:8] frame_length
    output logic [vfc_pkg::OUT_USER_W-1:0] m_tuser,  // [0] body_valid, [1] frame_good,
                                                     // [3:2] fault_kind
    output logic                          m_tlast    // frame_end
);
    import vfc_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    vfc_result_t       out_reg;
    vfc_result_t       result;
    logic              out_free;
    logic              advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata[BYTE_W-1:0];
        end
    end

    vfc_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.frame_length, out_reg.body_byte};
    assign m_tuser  = {out_reg.fault_kind, out_reg.frame_good, out_reg.body_valid};
    assign m_tlast  = out_reg.frame_end;

endmodule

// File: sv/vfc_checker.sv
`timescale 1ns / 1ps
`include "variable_frame_checker_macros.svh"

module vfc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [vfc_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [vfc_pkg::OUT_USER_W-1:0] m_tuser,
    input logic                           m_tlast
);
    import vfc_pkg::*;

    logic stalled;
    logic body_now;
    logic good_now;
    logic no_err;

    assign stalled  = m_tvalid && !m_tready;
    assign body_now = m_tuser[0];
    assign good_now = m_tuser[1];
    assign no_err   = (m_tuser[3:2] == ERR_NONE);

    `VFC_ASSERT_IMP(a_good_is_clean_end, aclk, aresetn, m_tvalid && good_now, m_tlast && no_err)
    `VFC_ASSERT_IMP(a_body_not_end, aclk, aresetn, m_tvalid && body_now, !m_tlast && !good_now)
    `VFC_ASSERT_IMP(a_err_only_at_end, aclk, aresetn, m_tvalid && !m_tlast, no_err && !good_now)
    `VFC_ASSERT_NEXT(a_stall_holds, aclk, aresetn, stalled, m_tvalid && $stable({m_tdata, m_tuser}))
    `VFC_ASSERT_NEXT_ALWAYS(a_reset_empties, aclk, !aresetn, !m_tvalid && s_tready)

endmodule

bind variable_frame_checker vfc_checker u_vfc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
